@@ design/fcs_pkg.sv @@
`default_nettype none
package fcs_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned LinkW     = 31;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned MagW      = 32;
  localparam int unsigned SqW       = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned ProdW     = MagW + LinkW;
  localparam int unsigned QuotW     = 64;

  // operation codes for the shared unit
  typedef enum logic [1:0] {
    OpSqrt = 2'd0,
    OpDiv  = 2'd1
  } unit_op_e;

  typedef struct packed {
    logic            start;
    unit_op_e        op;
    logic [SqW-1:0]  arg_a;
    logic [RootW-1:0] arg_b;
  } unit_req_t;

  typedef struct packed {
    logic            done;
    logic [QuotW-1:0] result;
  } unit_rsp_t;
endpackage
`default_nettype wire

@@ design/fcs_unit.sv @@
`default_nettype none
// shared radix-2 square root / divider, one result bit per cycle
module fcs_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fcs_pkg::unit_req_t req_i,
  output fcs_pkg::unit_rsp_t      rsp_o
);
  localparam int unsigned SqW   = fcs_pkg::SqW;
  localparam int unsigned RootW = fcs_pkg::RootW;
  localparam int unsigned QuotW = fcs_pkg::QuotW;

  logic              busy_q, busy_d;
  logic              op_q, op_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [SqW-1:0]    num_q, num_d;
  logic [SqW+1:0]    rem_q, rem_d;
  logic [QuotW-1:0]  res_q, res_d;
  logic [RootW-1:0]  den_q, den_d;
  logic              done_q, done_d;
  logic [SqW+1:0]    trial;

  always_comb begin
    busy_d = busy_q; op_d = op_q; cnt_d = cnt_q; num_d = num_q;
    rem_d = rem_q; res_d = res_q; den_d = den_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = (req_i.op == fcs_pkg::OpDiv);
      num_d  = req_i.arg_a;
      den_d  = req_i.arg_b;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = (req_i.op == fcs_pkg::OpDiv) ? 7'd64 : 7'd32;
    end else if (busy_q) begin
      if (op_q) begin
        // restoring division, one quotient bit
        trial = {rem_q[SqW:0], num_q[SqW-1]};
        num_d = {num_q[SqW-2:0], 1'b0};
        if (trial >= {{(SqW+2-RootW){1'b0}}, den_q}) begin
          rem_d = trial - {{(SqW+2-RootW){1'b0}}, den_q};
          res_d = {res_q[QuotW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          res_d = {res_q[QuotW-2:0], 1'b0};
        end
      end else begin
        // digit-by-digit root, two radicand bits
        trial = {rem_q[SqW-1:0], num_q[SqW-1:SqW-2]};
        num_d = {num_q[SqW-3:0], 2'b00};
        if (trial >= {res_q[SqW-1:0], 2'b01}) begin
          rem_d = trial - {res_q[SqW-1:0], 2'b01};
          res_d = {res_q[QuotW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          res_d = {res_q[QuotW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; num_q <= num_d; rem_q <= rem_d; res_q <= res_d; den_q <= den_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;
endmodule
`default_nettype wire

@@ design/fabrik_chain_solver_top.sv @@
`default_nettype none
// fabrik chain solver
// points enter one beat each on start/busy: base first, then joints, last the
// target with is_target_i set. non-target beats are stored and
// emit nothing; a full store (MAX_POINTS-1 held) drops further joints.
// the target beat starts one FABRIK iteration: end joint set to the target,
// a backward pass from joint count-3 down to 1, a forward pass from 1 up to
// count-2, each joint placed at link_length from its neighbor.
// one placement runs operand setup (StRd, StDiff, StSq), a 32-step square
// root and two 64-step divisions in the single shared iterative unit and
// a write-back in StWb; a zero-length difference skips the divisions. a run
// makes 2*count-5 placements, then gives one result beat per inner joint on
// valid_o, last_joint_o on the final one. fewer than three points gives one
// beat with too_few_o set, registered from StErr after the target beat.
// busy is high throughout the solve and output phase.
// results are shown for one cycle only; the receiver cannot stall.
// reset clears the point count and sets link_length to 1.0; the store
// itself is not cleared and needs no pass.
// cfg_we_i writes link_length; write it only while busy is low.
module fabrik_chain_solver_top #(
  parameter int unsigned MAX_POINTS = fcs_pkg::MaxPoints,
  parameter int unsigned FRAC_BITS  = fcs_pkg::FracBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [30:0] cfg_wdata_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic        is_target_i,
  output logic             valid_o,
  output logic [3:0]       joint_index_o,
  output logic signed [31:0] joint_x_o,
  output logic signed [31:0] joint_y_o,
  output logic             last_joint_o,
  output logic             too_few_o
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SqW = fcs_pkg::SqW;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StEnd   = 11'b00000000010,
    StRd    = 11'b00000000100,
    StDiff  = 11'b00000001000,
    StSq    = 11'b00000010000,
    StRoot  = 11'b00000100000,
    StDivX  = 11'b00001000000,
    StDivY  = 11'b00010000000,
    StWb    = 11'b00100000000,
    StOut   = 11'b01000000000,
    StErr   = 11'b10000000000
  } state_e;

  state_e st_q, st_d;
  logic signed [31:0] xs [MAX_POINTS];
  logic signed [31:0] ys [MAX_POINTS];
  logic [CW-1:0] cnt_q;
  logic [30:0]   link_q;
  logic [AW-1:0] k_q, a_q, last_q;
  logic          fwd_q;
  logic signed [31:0] kx_q, ky_q, ax_q, ay_q, tx_q, ty_q;
  logic signed [32:0] dx_q, dy_q;
  logic [31:0]   mx_q, my_q, len_q, ox_q, oy_q;
  logic [SqW-1:0] sq_q;
  logic          wait_q;
  logic          rd_q;
  logic [AW-1:0] oi_q;

  fcs_pkg::unit_req_t req;
  fcs_pkg::unit_rsp_t rsp;

  fcs_unit u_unit (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign busy = (st_q != StIdle);

  wire accept = start && !busy;

  // magnitudes with the halving for wide differences
  logic [32:0] amx, amy;
  assign amx = dx_q[32] ? (33'd0 - dx_q) : dx_q;
  assign amy = dy_q[32] ? (33'd0 - dy_q) : dy_q;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [63:0] rnd;
  assign rnd = {33'd0, len_q[31:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      cnt_q  <= '0;
      link_q <= 31'(64'd1 << FRAC_BITS);
      wait_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= (st_q == StErr) || ((st_q == StOut) && rd_q);
      if (cfg_we_i) link_q <= cfg_wdata_i;
      case (st_q)
        StIdle: if (accept) begin
          if (!is_target_i) begin
            if (cnt_q < CW'(MAX_POINTS - 1)) cnt_q <= cnt_q + 1'b1;
          end else begin
            cnt_q <= '0;
            if (cnt_q < CW'(2)) st_q <= StErr;
            else begin
              last_q <= AW'(cnt_q - 1'b1);
              st_q   <= StEnd;
            end
          end
        end
        StErr: begin
          joint_index_o <= '0; joint_x_o <= '0; joint_y_o <= '0;
          last_joint_o <= 1'b1; too_few_o <= 1'b1;
          st_q <= StIdle;
        end
        StEnd: begin
          if (last_q == AW'(1)) begin
            fwd_q <= 1'b1; k_q <= AW'(1); a_q <= '0;
          end else begin
            fwd_q <= 1'b0; k_q <= last_q - 1'b1; a_q <= last_q;
          end
          st_q <= StRd;
        end
        StRd: st_q <= StDiff;
        StDiff: begin
          dx_q <= {kx_q[31], kx_q} - {ax_q[31], ax_q};
          dy_q <= {ky_q[31], ky_q} - {ay_q[31], ay_q};
          st_q <= StSq;
        end
        StSq: begin
          if (amx[32] || amx[31] || amy[32] || amy[31]) begin
            mx_q <= amx[32:1]; my_q <= amy[32:1];
          end else begin
            mx_q <= amx[31:0]; my_q <= amy[31:0];
          end
          wait_q <= 1'b0;
          st_q <= StRoot;
        end
        StRoot: begin
          if (!wait_q) begin
            sq_q <= 64'(mx_q) * 64'(mx_q) + 64'(my_q) * 64'(my_q);
            wait_q <= 1'b1;
            rd_q <= 1'b0;
          end else if (!rd_q) rd_q <= 1'b1;
          else if (rsp.done) begin
            len_q <= rsp.result[31:0];
            wait_q <= 1'b0;
            if (rsp.result[31:0] == '0) begin
              ox_q <= '0; oy_q <= '0; st_q <= StWb;
            end else st_q <= StDivX;
          end
        end
        StDivX: begin
          if (!wait_q) begin
            sq_q <= 64'(mx_q) * 64'(link_q) + rnd; wait_q <= 1'b1; rd_q <= 1'b0;
          end else if (!rd_q) rd_q <= 1'b1;
          else if (rsp.done) begin
            ox_q <= rsp.result[31:0]; wait_q <= 1'b0; st_q <= StDivY;
          end
        end
        StDivY: begin
          if (!wait_q) begin
            sq_q <= 64'(my_q) * 64'(link_q) + rnd; wait_q <= 1'b1; rd_q <= 1'b0;
          end else if (!rd_q) rd_q <= 1'b1;
          else if (rsp.done) begin
            oy_q <= rsp.result[31:0]; wait_q <= 1'b0; st_q <= StWb;
          end
        end
        StWb: begin
          if (!fwd_q) begin
            if (k_q == AW'(1)) begin
              fwd_q <= 1'b1; k_q <= AW'(1); a_q <= '0;
            end else begin
              k_q <= k_q - 1'b1; a_q <= k_q;
            end
            st_q <= StRd;
          end else if (k_q == last_q) begin
            oi_q <= AW'(1); st_q <= StOut; rd_q <= 1'b0;
          end else begin
            a_q <= k_q; k_q <= k_q + 1'b1; st_q <= StRd;
          end
        end
        StOut: begin
          if (!rd_q) rd_q <= 1'b1;
          else begin
            joint_index_o <= 4'(oi_q);
            joint_x_o <= kx_q; joint_y_o <= ky_q;
            last_joint_o <= (oi_q == last_q);
            too_few_o <= 1'b0;
            rd_q <= 1'b0;
            if (oi_q == last_q) st_q <= StIdle;
            else oi_q <= oi_q + 1'b1;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // offset result (34-bit signed sum, ox below 2^32)
  logic signed [33:0] nx, ny;
  assign nx = {{2{ax_q[31]}}, ax_q} +
              (dx_q[32] ? -$signed({2'b00, ox_q}) : $signed({2'b00, ox_q}));
  assign ny = {{2{ay_q[31]}}, ay_q} +
              (dy_q[32] ? -$signed({2'b00, oy_q}) : $signed({2'b00, oy_q}));

  // store: write port and registered reads
  logic [AW-1:0] ra_k;
  assign ra_k = (st_q == StOut) ? oi_q : k_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q <= point_x_i; ty_q <= point_y_i;
    end
    if (accept && !(!is_target_i && cnt_q >= CW'(MAX_POINTS - 1))) begin
      xs[AW'(cnt_q)] <= point_x_i; ys[AW'(cnt_q)] <= point_y_i;
    end else if (st_q == StEnd) begin
      xs[last_q] <= tx_q; ys[last_q] <= ty_q;
    end else if (st_q == StWb) begin
      xs[k_q] <= sat(nx); ys[k_q] <= sat(ny);
    end
    kx_q <= xs[ra_k]; ky_q <= ys[ra_k];
    ax_q <= xs[a_q];  ay_q <= ys[a_q];
  end

  // unit request
  always_comb begin
    req.start = 1'b0;
    req.op    = fcs_pkg::OpSqrt;
    req.arg_a = sq_q;
    req.arg_b = len_q;
    if (wait_q && !rd_q) begin
      req.start = 1'b1;
      req.op = (st_q == StRoot) ? fcs_pkg::OpSqrt : fcs_pkg::OpDiv;
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_fabrik_chain_solver_top.sv @@
`default_nettype none
module tb_fabrik_chain_solver_top;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               tgt;
  } point_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               few;
  } joint_t;

  localparam int unsigned MaxPts   = fcs_pkg::MaxPoints;
  localparam longint      CycleCap = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we_i = 1'b0;
  logic [30:0]        cfg_wdata_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic               is_target_i = 1'b0;
  logic               valid_o;
  logic [3:0]         joint_index_o;
  logic signed [31:0] joint_x_o;
  logic signed [31:0] joint_y_o;
  logic               last_joint_o;
  logic               too_few_o;

  fabrik_chain_solver_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .point_x_i(point_x_i), .point_y_i(point_y_i), .is_target_i(is_target_i),
    .valid_o(valid_o), .joint_index_o(joint_index_o), .joint_x_o(joint_x_o),
    .joint_y_o(joint_y_o), .last_joint_o(last_joint_o), .too_few_o(too_few_o)
  );

  always #5 clk_i = ~clk_i;

  point_t  point_q[$];
  joint_t  joint_q[$];
  longint  chain_x[MaxPts];
  longint  chain_y[MaxPts];
  int      held;
  longint  link_len;
  int      fails;
  int      gap;
  bit      took;
  bit      no_gaps;
  longint  cycles;

  // exact integer square root
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // move joint k to link length from joint a along its direction
  function automatic void place_joint(int k, int a);
    longint dx, dy, sx, sy;
    longint unsigned mx, my, len, ox, oy;
    dx = chain_x[k] - chain_x[a];
    dy = chain_y[k] - chain_y[a];
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    ox = 0;
    oy = 0;
    if (mx >= 64'd2147483648 || my >= 64'd2147483648) begin
      mx >>= 1;
      my >>= 1;
    end
    len = int_sqrt(mx * mx + my * my);
    if (len != 0) begin
      ox = (mx * link_len + len / 2) / len;
      oy = (my * link_len + len / 2) / len;
    end
    sx = (dx < 0) ? -longint'(ox) : longint'(ox);
    sy = (dy < 0) ? -longint'(oy) : longint'(oy);
    chain_x[k] = clamp32(chain_x[a] + sx);
    chain_y[k] = clamp32(chain_y[a] + sy);
  endfunction

  // store a point; on the target run one iteration and queue the joints
  function automatic void solve_chain(point_t p);
    int n, last;
    joint_t j;
    if (!p.tgt) begin
      if (held < MaxPts - 1) begin
        chain_x[held] = longint'(p.x);
        chain_y[held] = longint'(p.y);
        held++;
      end
      return;
    end
    chain_x[held] = longint'(p.x);
    chain_y[held] = longint'(p.y);
    n = held + 1;
    held = 0;
    if (n < 3) begin
      j = '{idx: 4'd0, x: 32'sd0, y: 32'sd0, last: 1'b1, few: 1'b1};
      joint_q = {joint_q, j};
      return;
    end
    last = n - 2;
    chain_x[last] = chain_x[n-1];
    chain_y[last] = chain_y[n-1];
    for (int i = last - 1; i > 0; i--) place_joint(i, i + 1);
    for (int i = 1; i <= last; i++) place_joint(i, i - 1);
    for (int i = 1; i <= last; i++) begin
      j.idx = i[3:0];
      j.x = chain_x[i][31:0];
      j.y = chain_y[i][31:0];
      j.last = (i == last);
      j.few = 1'b0;
      joint_q = {joint_q, j};
    end
  endfunction

  // monitor: config, accepted beats and result checks
  always @(posedge clk_i) begin
    joint_t e;
    took = start && !busy && rst_ni;
    if (cfg_we_i) link_len = cfg_wdata_i;
    if (took) solve_chain('{x: point_x_i, y: point_y_i, tgt: is_target_i});
    if (rst_ni && valid_o) begin
      if (joint_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat idx=%0d", joint_index_o);
      end else begin
        e = joint_q.pop_front();
        if (joint_index_o !== e.idx || joint_x_o !== e.x || joint_y_o !== e.y ||
            last_joint_o !== e.last || too_few_o !== e.few) begin
          fails++;
          if (fails <= 10)
            $display({"mismatch exp idx=%0d x=%0d y=%0d last=%0b few=%0b",
                      " got idx=%0d x=%0d y=%0d last=%0b few=%0b"},
                     e.idx, e.x, e.y, e.last, e.few, joint_index_o, joint_x_o,
                     joint_y_o, last_joint_o, too_few_o);
        end
      end
    end
  end

  // driver: one beat at a time from point_q with random gaps unless no_gaps is set
  always @(negedge clk_i) begin
    point_t p;
    logic   nxt_start;
    nxt_start = start;
    if (rst_ni && !(start && !took)) begin
      nxt_start = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (point_q.size() != 0) begin
        p = point_q.pop_front();
        point_x_i <= p.x;
        point_y_i <= p.y;
        is_target_i <= p.tgt;
        nxt_start = 1'b1;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
      end
    end
    start <= nxt_start;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("fabrik_chain_solver_top regression: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic void add_point(logic signed [31:0] x, logic signed [31:0] y, logic t);
    point_t p;
    p = '{x: x, y: y, tgt: t};
    point_q = {point_q, p};
  endfunction

  // chain of n points, the last one the target
  function automatic void add_chain(int n, bit wide);
    for (int i = 0; i < n; i++) add_point(rand_coord(wide), rand_coord(wide), i == n - 1);
  endfunction

  task automatic wait_idle();
    while (point_q.size() != 0 || start || joint_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_link(logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    held = 0;
    link_len = 64'd65536;
    fails = 0;
    gap = 0;
    took = 1'b0;
    no_gaps = 1'b0;
    cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: too few points, minimal chain, coincident points, extremes
    add_point(32'sd5, 32'sd7, 1'b1);
    add_point(32'sd0, 32'sd0, 1'b0);
    add_point(32'sd100, -32'sd100, 1'b1);
    add_point(32'sd0, 32'sd0, 1'b0);
    add_point(32'sh0001_0000, 32'sd0, 1'b0);
    add_point(32'sh0003_0000, 32'sh0002_0000, 1'b1);
    add_point(32'sd1000, 32'sd1000, 1'b0);
    add_point(32'sd1000, 32'sd1000, 1'b0);
    add_point(32'sd1000, 32'sd1000, 1'b0);
    add_point(32'sd1000, 32'sd1000, 1'b1);
    add_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    add_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    add_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    wait_idle();

    // store full: extra joints dropped
    add_chain(20, 1'b0);
    wait_idle();

    // extremes of the segment length
    write_link(31'd0);
    add_chain(5, 1'b0);
    add_chain(4, 1'b1);
    wait_idle();
    write_link(31'h7fff_ffff);
    add_chain(6, 1'b0);
    add_chain(5, 1'b1);
    wait_idle();

    // random phases with fresh settings
    sent = 0;
    for (int ph = 0; sent < 500; ph++) begin
      case (ph % 4)
        0: write_link(31'd65536);
        1: write_link(31'($urandom_range(0, 32'h0004_0000)));
        2: write_link(31'($urandom));
        default: write_link(ph % 8 == 3 ? 31'h7fff_ffff : 31'd0);
      endcase
      no_gaps = (ph % 3 == 2);
      for (int c = 0; c < 12; c++) begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(12, 19);
        else n = $urandom_range(3, 8);
        // each chain ends in its target; about one chain in four uses wide coordinates
        add_chain(n, $urandom_range(0, 3) == 0);
        sent += n;
      end
      wait_idle();
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (fails == 0 && joint_q.size() == 0) begin
      $display("fabrik_chain_solver_top regression: pass");
    end else begin
      $display("fabrik_chain_solver_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/fcs_pkg.sv
design/fcs_unit.sv
design/fabrik_chain_solver_top.sv
sim/tb_fabrik_chain_solver_top.sv
